>>> sv/smavg_pkg.sv
// Shared widths, codes, thresholds and helpers for the supply monitor averager.
package smavg_pkg;

    // Sample accumulation
    localparam int SAMPLE_W            = 12;
    localparam int SPR_LOG2            = 3;
    localparam int SAMPLES_PER_READING = 1 << SPR_LOG2;
    localparam int CNT_W               = SPR_LOG2;
    localparam int SUM_W               = SAMPLE_W + SPR_LOG2;

    // Configuration registers
    localparam int VREF_W     = 13;
    localparam int RATIO_W    = 4;
    localparam int RES_W      = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_VREF   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_RATIO  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_CUR_EN = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_RES    = 2'd3;

    localparam logic [VREF_W-1:0]  VREF_RST  = 13'd3300;
    localparam logic [RATIO_W-1:0] RATIO_RST = 4'd3;

    // Result fields
    localparam int VAL_W  = 16;
    localparam int TYPE_W = 3;
    localparam int PCT_W  = 7;

    // Serial arithmetic units
    localparam int MUL_W  = 35;   // avg * vref * 1000 fits here
    localparam int MPLR_W = 13;   // widest multiplier operand (vref)
    localparam int QUO_W  = MUL_W;
    localparam int DVSR_W = 16;
    localparam int Q1_W   = 24;   // quotient of a MUL_W product by full scale

    localparam int FULL_SCALE = 4095;
    localparam int UV_PER_MV  = 1000;
    localparam int PCT_SCALE  = 100;

    localparam logic [VAL_W-1:0] VALUE_MAX = 16'hFFFF;

    // Supply type codes
    localparam logic [TYPE_W-1:0] SUP_UNKNOWN = 3'd0;
    localparam logic [TYPE_W-1:0] SUP_USB     = 3'd1;
    localparam logic [TYPE_W-1:0] SUP_LIPO1S  = 3'd2;
    localparam logic [TYPE_W-1:0] SUP_LIPO2S  = 3'd3;
    localparam logic [TYPE_W-1:0] SUP_ALK4    = 3'd4;
    localparam logic [TYPE_W-1:0] SUP_ALK6    = 3'd5;

    // Classification thresholds in millivolts
    localparam logic [VAL_W-1:0] TH_LIPO1S = 16'd3500;
    localparam logic [VAL_W-1:0] TH_USB    = 16'd4500;
    localparam logic [VAL_W-1:0] TH_ALK4   = 16'd5500;
    localparam logic [VAL_W-1:0] TH_LIPO2S = 16'd6500;
    localparam logic [VAL_W-1:0] TH_ALK6   = 16'd8000;
    localparam logic [VAL_W-1:0] TH_TOP    = 16'd10000;

    // Charge interpolation end points
    localparam logic [VAL_W-1:0] LIPO1S_LO = 16'd3000;
    localparam logic [VAL_W-1:0] LIPO1S_HI = 16'd4200;
    localparam logic [VAL_W-1:0] LIPO2S_LO = 16'd6000;
    localparam logic [VAL_W-1:0] LIPO2S_HI = 16'd8400;

    localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;
    localparam logic [PCT_W-1:0] PCT_HALF  = 7'd50;
    localparam logic [PCT_W-1:0] PCT_EMPTY = 7'd0;

    // Stream words
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_AVG_LSB  = 0;
    localparam int OUT_VAL_LSB  = OUT_AVG_LSB + SAMPLE_W;
    localparam int OUT_TYPE_LSB = OUT_VAL_LSB + VAL_W;
    localparam int OUT_PCT_LSB  = OUT_TYPE_LSB + TYPE_W;
    localparam int OUT_PAD_LSB  = OUT_PCT_LSB + PCT_W;

    function automatic logic [TYPE_W-1:0] classify(input logic [VAL_W-1:0] mv);
        logic [TYPE_W-1:0] t;
        if (mv < TH_LIPO1S)      t = SUP_UNKNOWN;
        else if (mv < TH_USB)    t = SUP_LIPO1S;
        else if (mv < TH_ALK4)   t = SUP_USB;
        else if (mv < TH_LIPO2S) t = SUP_ALK4;
        else if (mv < TH_ALK6)   t = SUP_LIPO2S;
        else if (mv < TH_TOP)    t = SUP_ALK6;
        else                     t = SUP_UNKNOWN;
        return t;
    endfunction

    function automatic logic [VAL_W-1:0] sat_val(input logic [QUO_W-1:0] q);
        return (|q[QUO_W-1:VAL_W]) ? VALUE_MAX : q[VAL_W-1:0];
    endfunction

endpackage

>>> sv/supply_monitor_averager_core.sv
// Supply monitor averager: sample accumulation, serial scaling and reading output.
//
//  channel   | direction | handshake             | payload
//  ----------+-----------+-----------------------+---------------------------------------
//  s stream  | in        | i_s_tvalid/o_s_tready | tdata: sample; tuser: req_type
//  m stream  | out       | o_m_tvalid/i_m_tready | tdata: raw_average, value, supply_type,
//            |           |                       |        charge_percent; tuser: reading_kind
//  cfg       | in        | i_cfg_we              | i_cfg_addr, i_cfg_data
//
//  A sample is summed in the cycle it is accepted; one word per cycle while a run fills.
//  The run's last word starts the shared multiplier and divider; the reading loads into the
//  output register after avg * vref, * ratio or * 1000 and / full scale for voltage or
//  disabled current, adding / resistance for current or * 100 and / span for lithium charge.
//  The next run's last word stalls (o_s_tready low) until then; a full output register
//  stalls the sequencer. Synchronous active-low reset clears run, sequencer and config.
module supply_monitor_averager_core import smavg_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // slave stream
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // [11:0] sample, [15:12] zero
    input  logic                   i_s_tuser,   // [0] req_type
    // master stream
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,   // [11:0] raw_average, [27:12] value,
                                                // [30:28] supply_type, [37:31] charge_percent,
                                                // [39:38] zero
    output logic                   o_m_tuser,   // [0] reading_kind
    // configuration
    input  logic                   i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);
    // Sequencer states
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_MUL1 = 4'd1;   // avg * vref
    localparam logic [3:0] ST_MUL2 = 4'd2;   // * divider ratio or * 1000
    localparam logic [3:0] ST_DIV1 = 4'd3;   // / full scale
    localparam logic [3:0] ST_EVAL = 4'd4;   // classify, pick the next step
    localparam logic [3:0] ST_MUL3 = 4'd5;   // (mv - lo) * 100
    localparam logic [3:0] ST_DIV2 = 4'd6;   // / span or / sense resistance
    localparam logic [3:0] ST_DONE = 4'd7;   // hand over to the output register

    // Configuration
    logic [VREF_W-1:0]  r_vref;
    logic [RATIO_W-1:0] r_ratio;
    logic               r_cur_en;
    logic [RES_W-1:0]   r_res;

    // Run accumulation
    logic [SUM_W-1:0]    r_sum;
    logic [CNT_W-1:0]    r_cnt;
    logic [SUM_W-1:0]    run_sum;
    logic [SAMPLE_W-1:0] run_avg;
    logic                in_acc;
    logic                run_done;

    // Sequencer and reading payload
    logic [3:0]          r_state, n_state;
    logic                r_kind, n_kind;
    logic [SAMPLE_W-1:0] r_avg, n_avg;
    logic [Q1_W-1:0]     r_q1, n_q1;
    logic [VAL_W-1:0]    r_val, n_val;
    logic [TYPE_W-1:0]   r_type, n_type;
    logic [PCT_W-1:0]    r_pct, n_pct;
    logic [VAL_W-1:0]    lo_mv, hi_mv;
    logic                out_load;

    // Arithmetic units
    logic               mul_start, mul_done;
    logic [MUL_W-1:0]   mul_mcand, mul_prod;
    logic [MPLR_W-1:0]  mul_mplier;
    logic               div_start, div_done;
    logic [QUO_W-1:0]   div_dividend, div_quo;
    logic [DVSR_W-1:0]  div_divisor;

    // Output register
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic                   r_out_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vref   <= VREF_RST;
            r_ratio  <= RATIO_RST;
            r_cur_en <= 1'b0;
            r_res    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_VREF:   r_vref   <= i_cfg_data[VREF_W-1:0];
                REG_RATIO:  r_ratio  <= i_cfg_data[RATIO_W-1:0];
                REG_CUR_EN: r_cur_en <= i_cfg_data[0];
                REG_RES:    r_res    <= i_cfg_data[RES_W-1:0];
                default: ;
            endcase
        end
    end

    // Hold off only the word that closes a run while a reading is still in flight.
    assign o_s_tready = !((r_cnt == CNT_W'(SAMPLES_PER_READING - 1)) && (r_state != ST_IDLE));
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign run_done   = in_acc && (r_cnt == CNT_W'(SAMPLES_PER_READING - 1));
    assign run_sum    = r_sum + SUM_W'(i_s_tdata[SAMPLE_W-1:0]);
    assign run_avg    = run_sum[SUM_W-1:SPR_LOG2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_cnt <= '0;
        end else if (in_acc) begin
            r_sum <= run_done ? '0 : run_sum;
            r_cnt <= run_done ? '0 : r_cnt + 1'b1;
        end
    end

    // Interpolation end points for the two lithium types
    assign lo_mv = (r_type == SUP_LIPO2S) ? LIPO2S_LO : LIPO1S_LO;
    assign hi_mv = (r_type == SUP_LIPO2S) ? LIPO2S_HI : LIPO1S_HI;

    always_comb begin
        n_state      = r_state;
        n_kind       = r_kind;
        n_avg        = r_avg;
        n_q1         = r_q1;
        n_val        = r_val;
        n_type       = r_type;
        n_pct        = r_pct;
        mul_start    = 1'b0;
        mul_mcand    = '0;
        mul_mplier   = '0;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        out_load     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (run_done) begin
                    mul_start  = 1'b1;
                    mul_mcand  = MUL_W'(run_avg);
                    mul_mplier = r_vref;
                    n_kind     = i_s_tuser;
                    n_avg      = run_avg;
                    n_state    = ST_MUL1;
                end
            end
            ST_MUL1: begin
                if (mul_done) begin
                    mul_start  = 1'b1;
                    mul_mcand  = mul_prod;
                    mul_mplier = r_kind ? MPLR_W'(UV_PER_MV) : MPLR_W'(r_ratio);
                    n_state    = ST_MUL2;
                end
            end
            ST_MUL2: begin
                if (mul_done) begin
                    div_start    = 1'b1;
                    div_dividend = mul_prod;
                    div_divisor  = DVSR_W'(FULL_SCALE);
                    n_state      = ST_DIV1;
                end
            end
            ST_DIV1: begin
                if (div_done) begin
                    n_q1    = div_quo[Q1_W-1:0];
                    n_val   = sat_val(div_quo);
                    n_type  = r_kind ? SUP_UNKNOWN : classify(sat_val(div_quo));
                    n_pct   = PCT_EMPTY;
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (r_kind) begin
                    if (r_cur_en && (r_res != '0)) begin
                        div_start    = 1'b1;
                        div_dividend = QUO_W'(r_q1);
                        div_divisor  = r_res;
                        n_state      = ST_DIV2;
                    end else begin
                        n_val   = '0;
                        n_state = ST_DONE;
                    end
                end else begin
                    case (r_type)
                        SUP_USB: begin
                            n_pct   = PCT_FULL;
                            n_state = ST_DONE;
                        end
                        SUP_LIPO1S, SUP_LIPO2S: begin
                            if (r_val <= lo_mv) begin
                                n_pct   = PCT_EMPTY;
                                n_state = ST_DONE;
                            end else if (r_val >= hi_mv) begin
                                n_pct   = PCT_FULL;
                                n_state = ST_DONE;
                            end else begin
                                mul_start  = 1'b1;
                                mul_mcand  = MUL_W'(r_val - lo_mv);
                                mul_mplier = MPLR_W'(PCT_SCALE);
                                n_state    = ST_MUL3;
                            end
                        end
                        default: begin
                            n_pct   = PCT_HALF;
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_MUL3: begin
                if (mul_done) begin
                    div_start    = 1'b1;
                    div_dividend = mul_prod;
                    div_divisor  = hi_mv - lo_mv;
                    n_state      = ST_DIV2;
                end
            end
            ST_DIV2: begin
                if (div_done) begin
                    if (r_kind) begin
                        n_val = sat_val(div_quo);
                    end else begin
                        n_pct = div_quo[PCT_W-1:0];
                    end
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // Advance only when the output register is free or draining.
                if (!r_out_valid || i_m_tready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_avg  <= n_avg;
        r_q1   <= n_q1;
        r_val  <= n_val;
        r_type <= n_type;
        r_pct  <= n_pct;
    end

    smavg_smul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_mcand  (mul_mcand),
        .i_mplier (mul_mplier),
        .o_done   (mul_done),
        .o_prod   (mul_prod)
    );

    smavg_sdiv u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quo      (div_quo)
    );

    // Output register: a finished reading waits here while the next run fills.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= {(OUT_TDATA_W - OUT_PAD_LSB)'(0), r_pct, r_type, r_val, r_avg};
            r_out_kind <= r_kind;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_kind;

endmodule

>>> sv/smavg_smul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
module smavg_smul import smavg_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [MUL_W-1:0]  i_mcand,
    input  logic [MPLR_W-1:0] i_mplier,
    output logic              o_done,
    output logic [MUL_W-1:0]  o_prod
);
    localparam int STEP_W = $clog2(MPLR_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [MUL_W-1:0]  r_acc;
    logic [MUL_W-1:0]  r_mcand;
    logic [MPLR_W-1:0] r_mplier;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(MPLR_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc    <= '0;
            r_mcand  <= i_mcand;
            r_mplier <= i_mplier;
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand  <= {r_mcand[MUL_W-2:0], 1'b0};
            r_mplier <= {1'b0, r_mplier[MPLR_W-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

>>> sv/smavg_sdiv.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module smavg_sdiv import smavg_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [QUO_W-1:0]  i_dividend,
    input  logic [DVSR_W-1:0] i_divisor,
    output logic              o_done,
    output logic [QUO_W-1:0]  o_quo
);
    localparam int STEP_W = $clog2(QUO_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [QUO_W-1:0]  r_quo;
    logic [DVSR_W-1:0] r_rem;
    logic [DVSR_W-1:0] r_dvsr;

    logic [DVSR_W:0]   shifted;
    logic [DVSR_W:0]   diff;
    logic              fits;

    // Bring down the next dividend bit; subtract when the divisor fits.
    assign shifted = {r_rem, r_quo[QUO_W-1]};
    assign diff    = shifted - {1'b0, r_dvsr};
    assign fits    = (shifted >= {1'b0, r_dvsr});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(QUO_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo  <= i_dividend;
            r_rem  <= '0;
            r_dvsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? diff[DVSR_W-1:0] : shifted[DVSR_W-1:0];
            r_quo <= {r_quo[QUO_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

>>> sv/smavg_chk.sv
// Port-level checker for the supply monitor averager, bound to the top level.
module smavg_chk import smavg_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_out_tvalid,
    input logic                   i_out_tready,
    input logic [OUT_TDATA_W-1:0] i_out_tdata,
    input logic                   i_out_tuser
);
    logic [VAL_W-1:0]  chk_val;
    logic [TYPE_W-1:0] chk_type;
    logic [PCT_W-1:0]  chk_pct;

    assign chk_val  = i_out_tdata[OUT_TYPE_LSB-1:OUT_VAL_LSB];
    assign chk_type = i_out_tdata[OUT_PCT_LSB-1:OUT_TYPE_LSB];
    assign chk_pct  = i_out_tdata[OUT_PAD_LSB-1:OUT_PCT_LSB];

    // Stalled word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_tvalid && !i_out_tready |=>
            i_out_tvalid && $stable(i_out_tdata) && $stable(i_out_tuser))
        else $error("output word changed while stalled");

    // Reset empties the output register.
    a_out_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_tvalid)
        else $error("output valid after reset");

    // Current readings carry no supply type and no charge.
    a_cur_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_tvalid && i_out_tuser |-> (chk_type == SUP_UNKNOWN) && (chk_pct == PCT_EMPTY))
        else $error("current reading with type or percent");

    // USB supplies always report full charge.
    a_usb_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_tvalid && !i_out_tuser && (chk_type == SUP_USB) |-> (chk_pct == PCT_FULL))
        else $error("usb reading not at full charge");

    // Voltage below the lowest band is unknown at half charge.
    a_low_unknown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_tvalid && !i_out_tuser && (chk_val < TH_LIPO1S) |->
            (chk_type == SUP_UNKNOWN) && (chk_pct == PCT_HALF))
        else $error("low voltage misclassified");

endmodule

bind supply_monitor_averager_core smavg_chk u_smavg_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_tvalid (o_m_tvalid),
    .i_out_tready (i_m_tready),
    .i_out_tdata  (o_m_tdata),
    .i_out_tuser  (o_m_tuser)
);

>>> dv/supply_monitor_averager_core_tb.sv
// Self-checking testbench for the supply monitor averager core: stream stimulus, predicted readings.
module supply_monitor_averager_core_tb;
    import smavg_pkg::*;

    // One reading as it leaves the master stream
    typedef struct packed {
        logic               kind;
        logic [SAMPLE_W-1:0] avg;
        logic [VAL_W-1:0]   val;
        logic [TYPE_W-1:0]  sup;
        logic [PCT_W-1:0]   pct;
    } t_reading;

    // One row of the directed table: a sample word, its tag, and an optional typed reading
    typedef struct packed {
        logic [SAMPLE_W-1:0] smp;
        logic               kind;
        logic               typed;
        t_reading           exp;
    } t_stim_row;

    localparam int NUM_PHASES    = 12;
    localparam int RUNS_PER_PHASE = 12;
    localparam int SETTLE_CYCLES = 200;   // the longest reading is a lithium one
    localparam int HOLD_CYCLES   = 600;   // long enough for the core to back up to its input
    localparam int IDLE_LIMIT    = 4000;
    localparam int MAX_REPORTS   = 10;

    // Millivolt marks around which near-boundary runs are aimed
    localparam int MV_MARKS [0:10] = '{3000, 3500, 4200, 4500, 5500, 6000, 6500, 8000,
                                       8400, 10000, 65535};

    // Directed table: a full-scale voltage run, an all-zero current run with the
    // current channel still off, and a run whose tags alternate, closed by a voltage tag.
    localparam t_stim_row DIRECTED [0:23] = '{
        '{12'hFFF, 1'b0, 1'b0, '0}, '{12'hFFF, 1'b0, 1'b0, '0},
        '{12'hFFF, 1'b0, 1'b0, '0}, '{12'hFFF, 1'b0, 1'b0, '0},
        '{12'hFFF, 1'b0, 1'b0, '0}, '{12'hFFF, 1'b0, 1'b0, '0},
        '{12'hFFF, 1'b0, 1'b0, '0},
        '{12'hFFF, 1'b0, 1'b1, '{1'b0, 12'd4095, 16'd9900, SUP_ALK6, PCT_HALF}},
        '{12'h000, 1'b1, 1'b0, '0}, '{12'h000, 1'b1, 1'b0, '0},
        '{12'h000, 1'b1, 1'b0, '0}, '{12'h000, 1'b1, 1'b0, '0},
        '{12'h000, 1'b1, 1'b0, '0}, '{12'h000, 1'b1, 1'b0, '0},
        '{12'h000, 1'b1, 1'b0, '0},
        '{12'h000, 1'b1, 1'b1, '{1'b1, 12'd0, 16'd0, SUP_UNKNOWN, PCT_EMPTY}},
        '{12'hAAA, 1'b1, 1'b0, '0}, '{12'h555, 1'b0, 1'b0, '0},
        '{12'hAAA, 1'b1, 1'b0, '0}, '{12'h555, 1'b0, 1'b0, '0},
        '{12'hAAA, 1'b1, 1'b0, '0}, '{12'h555, 1'b0, 1'b0, '0},
        '{12'hAAA, 1'b1, 1'b0, '0}, '{12'h555, 1'b0, 1'b0, '0}
    };

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata = '0;
    logic                   i_s_tuser = 1'b0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   o_m_tuser;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    // Predictor copy of the configuration, at its reset values
    logic [VREF_W-1:0]  cfg_vref = VREF_RST;
    logic [RATIO_W-1:0] cfg_ratio = RATIO_RST;
    logic               cfg_cur_en = 1'b0;
    logic [RES_W-1:0]   cfg_res = '0;

    // Predictor copy of the run in progress
    int unsigned run_sum = 0;
    int unsigned run_cnt = 0;

    t_reading pending_readings [$];
    int       mismatches = 0;

    // Idling controls; the receiver owns its hold-off counter
    int   src_idle_pct = 0;
    int   sink_stall_pct = 0;
    logic hold_tog = 1'b0;
    logic hold_seen = 1'b0;
    int   hold_left = 0;

    supply_monitor_averager_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [VAL_W-1:0] clip_value(input logic [63:0] wide);
        return (wide > 64'(VALUE_MAX)) ? VALUE_MAX : wide[VAL_W-1:0];
    endfunction

    // Map millivolts to a supply type by the fixed threshold ladder
    function automatic logic [TYPE_W-1:0] supply_class(input logic [VAL_W-1:0] mv);
        if (mv < TH_LIPO1S) return SUP_UNKNOWN;
        if (mv < TH_USB)    return SUP_LIPO1S;
        if (mv < TH_ALK4)   return SUP_USB;
        if (mv < TH_LIPO2S) return SUP_ALK4;
        if (mv < TH_ALK6)   return SUP_LIPO2S;
        if (mv < TH_TOP)    return SUP_ALK6;
        return SUP_UNKNOWN;
    endfunction

    // USB is full, lithium packs interpolate between their end points, the rest sit at half
    function automatic logic [PCT_W-1:0] charge_of(input logic [TYPE_W-1:0] sup,
                                                   input logic [VAL_W-1:0] mv);
        int unsigned lo;
        int unsigned hi;
        if (sup == SUP_USB) return PCT_FULL;
        if (sup == SUP_LIPO1S) begin
            lo = LIPO1S_LO;
            hi = LIPO1S_HI;
        end else if (sup == SUP_LIPO2S) begin
            lo = LIPO2S_LO;
            hi = LIPO2S_HI;
        end else begin
            return PCT_HALF;
        end
        if (mv <= lo) return PCT_EMPTY;
        if (mv >= hi) return PCT_FULL;
        return PCT_W'(((mv - lo) * PCT_SCALE) / (hi - lo));
    endfunction

    // Add one accepted sample to the run; return 1 with the reading when the run closes
    function automatic bit accumulate_sample(input logic [SAMPLE_W-1:0] smp, input logic kind,
                                             output t_reading r);
        logic [63:0] wide;
        r = '0;
        run_sum += smp;
        run_cnt++;
        if (run_cnt < SAMPLES_PER_READING) return 1'b0;
        r.kind = kind;
        r.avg = SAMPLE_W'(run_sum / SAMPLES_PER_READING);
        run_sum = 0;
        run_cnt = 0;
        if (kind == 1'b0) begin
            wide = (64'(r.avg) * 64'(cfg_vref) * 64'(cfg_ratio)) / 64'(FULL_SCALE);
            r.val = clip_value(wide);
            r.sup = supply_class(r.val);
            r.pct = charge_of(r.sup, r.val);
        end else if (cfg_cur_en && cfg_res != '0) begin
            wide = (64'(r.avg) * 64'(cfg_vref) * 64'(UV_PER_MV)) / 64'(FULL_SCALE);
            r.val = clip_value(wide / 64'(cfg_res));
        end
        return 1'b1;
    endfunction

    // Offer one sample word, hold it until taken, and log what it should produce.
    // Valid stays high into the next word unless an idle gap is drawn.
    task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic kind,
                               input logic typed, input t_reading typed_exp);
        t_reading r;
        if ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= IN_TDATA_W'(smp);
        i_s_tuser  <= kind;
        do @(posedge i_clk); while (!o_s_tready);
        if (accumulate_sample(smp, kind, r))
            pending_readings.push_back(typed ? typed_exp : r);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input int unsigned v);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= CFG_DATA_W'(v);
        @(posedge i_clk);
        case (idx)
            REG_VREF:   cfg_vref   = VREF_W'(v);
            REG_RATIO:  cfg_ratio  = RATIO_W'(v);
            REG_CUR_EN: cfg_cur_en = v[0];
            REG_RES:    cfg_res    = RES_W'(v);
            default: ;
        endcase
    endtask

    // Drop valid and let every outstanding reading drain, then give the
    // sequencer time to finish a run that produces nothing further.
    task automatic drain_and_settle();
        i_s_tvalid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic note_mismatch(input string field, input longint want, input longint got);
        if (mismatches < MAX_REPORTS)
            $display("MISMATCH %s: expected %0d, got %0d at %0t", field, want, got, $time);
        mismatches++;
    endtask

    // Receiver: a requested hold-off wins over the per-cycle random stall
    always @(posedge i_clk) begin
        if (hold_tog != hold_seen) begin
            hold_seen  <= hold_tog;
            hold_left  <= HOLD_CYCLES;
            i_m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left  <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Compare each word taken from the master stream with the oldest prediction
    always @(posedge i_clk) begin : check_reading
        t_reading got;
        t_reading want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.kind = o_m_tuser;
            got.avg  = o_m_tdata[OUT_AVG_LSB +: SAMPLE_W];
            got.val  = o_m_tdata[OUT_VAL_LSB +: VAL_W];
            got.sup  = o_m_tdata[OUT_TYPE_LSB +: TYPE_W];
            got.pct  = o_m_tdata[OUT_PCT_LSB +: PCT_W];
            if (pending_readings.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $display("MISMATCH unexpected reading %h at %0t", got, $time);
                mismatches++;
            end else begin
                want = pending_readings.pop_front();
                if (got.kind != want.kind) note_mismatch("reading_kind", want.kind, got.kind);
                if (got.avg != want.avg)   note_mismatch("raw_average", want.avg, got.avg);
                if (got.val != want.val)   note_mismatch("value", want.val, got.val);
                if (got.sup != want.sup)   note_mismatch("supply_type", want.sup, got.sup);
                if (got.pct != want.pct)   note_mismatch("charge_percent", want.pct, got.pct);
            end
        end
    end

    // Watchdog: end the run when no word moves on either side for too long
    always @(posedge i_clk) begin : watchdog
        int idle_cycles;
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int          base;
        int          smp;
        int          mv;
        int          scale;
        logic        run_kind;
        logic        mixed;
        int unsigned vref;
        int unsigned ratio;
        int unsigned cur_en;
        int unsigned res;

        // Hold reset, then release it for good
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table under the reset configuration
        foreach (DIRECTED[i])
            send_sample(DIRECTED[i].smp, DIRECTED[i].kind, DIRECTED[i].typed, DIRECTED[i].exp);

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_and_settle();

            // Early phases pin the extremes, later ones draw settings at random
            case (p)
                0: begin vref = 3300; ratio = 3;  cur_en = 1; res = 100;   end
                1: begin vref = 1000; ratio = 1;  cur_en = 1; res = 1;     end
                2: begin vref = 5000; ratio = 15; cur_en = 1; res = 65535; end
                3: begin vref = 8191; ratio = 15; cur_en = 1; res = 0;     end
                4: begin vref = 0;    ratio = 0;  cur_en = 0; res = 50;    end
                5: begin vref = 5000; ratio = 15; cur_en = 0; res = 1;     end
                default: begin
                    vref = ($urandom_range(7) == 0) ? $urandom_range(8191)
                                                    : $urandom_range(5000, 1000);
                    ratio  = $urandom_range(15);
                    cur_en = ($urandom_range(3) != 0) ? 1 : 0;
                    case ($urandom_range(7))
                        0:       res = 0;
                        1:       res = 65535;
                        2:       res = $urandom_range(65535);
                        default: res = $urandom_range(3000, 1);
                    endcase
                end
            endcase
            write_reg(REG_VREF, vref);
            write_reg(REG_RATIO, ratio);
            write_reg(REG_CUR_EN, cur_en);
            write_reg(REG_RES, res);
            i_cfg_we <= 1'b0;

            // Rotate through the idling patterns
            case (p % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 69; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 69; end
                default: begin src_idle_pct = 28; sink_stall_pct = 28; end
            endcase

            // Freeze the receiver while samples keep coming, so the core backs up
            if (p == 4 || p == 8) hold_tog <= ~hold_tog;

            for (int r = 0; r < RUNS_PER_PHASE; r++) begin
                // Aim the run at a full-range value, an extreme, or near a boundary
                case ($urandom_range(3))
                    0: base = $urandom_range(4095);
                    1: base = ($urandom_range(1) != 0) ? 4095 : $urandom_range(3);
                    default: begin
                        mv = MV_MARKS[$urandom_range(10)] + $urandom_range(40) - 20;
                        scale = cfg_vref * cfg_ratio;
                        base = (scale != 0) ? (mv * FULL_SCALE) / scale : $urandom_range(4095);
                        if (base > 4095) base = 4095;
                    end
                endcase
                run_kind = 1'($urandom_range(1));
                mixed = ($urandom_range(7) == 0);
                for (int s = 0; s < SAMPLES_PER_READING; s++) begin
                    if ($urandom_range(9) == 0)
                        smp = $urandom_range(4095);
                    else
                        smp = base + $urandom_range(6) - 3;
                    if (smp < 0) smp = 0;
                    if (smp > 4095) smp = 4095;
                    send_sample(SAMPLE_W'(smp), mixed ? 1'($urandom_range(1)) : run_kind,
                                1'b0, '0);
                end
            end
        end

        // Let every reading arrive, then watch a little longer for strays
        drain_and_settle();
        if (mismatches == 0 && pending_readings.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
